>>> rtl/core/pac_pkg.sv
`timescale 1ns / 1ps

package pac_pkg;

    // Four byte lanes of one premultiplied pixel, lane k at bits 8k+7:8k.
    typedef logic [3:0][7:0] t_px;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_RED_LANE      = 3'd0,
        REG_GREEN_LANE    = 3'd1,
        REG_BLUE_LANE     = 3'd2,
        REG_ALPHA_LANE    = 3'd3,
        REG_BG_MODE       = 3'd4,
        REG_FIRST_COLOR   = 3'd5,
        REG_SECOND_COLOR  = 3'd6,
        REG_PREVIEW_WIDTH = 3'd7
    } t_reg_idx;

    // Background modes; the unused code behaves as no background.
    localparam logic [1:0] BG_NONE  = 2'd0;
    localparam logic [1:0] BG_SOLID = 2'd1;
    localparam logic [1:0] BG_CHECK = 2'd2;

    localparam logic [7:0] ALPHA_MAX = 8'd255;
    localparam logic [7:0] ALPHA_MIN = 8'd0;

    // Exact floor(x / 255) for any x up to 255 * 255.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
        return s[15:8];
    endfunction

    // floor(c * na / 255), the weighted contribution of one lane.
    function automatic logic [7:0] blend_term(input logic [7:0] c, input logic [7:0] na);
        logic [15:0] p;
        p = c * na;
        return div255(p);
    endfunction

endpackage

>>> rtl/core/premultiplied_alpha_compositor_top.sv
`timescale 1ns / 1ps

// Premultiplied alpha compositor: takes one preview pixel with its back and front layer
// pixels per transfer and returns one composited pixel. The back pixel goes under the
// preview pixel, an optional solid or 16-pixel checkerboard background goes under that,
// and the front pixel goes over the result. The pipeline accepts one pixel every clock
// unless stalled. It has one stage for the back blend, one for the background, and four
// for the front blend, one per lane update, so that lanes mapped onto the same byte are
// applied in order. Backpressure stalls only the occupied stages, so bubbles are
// absorbed. Configuration must be written only while idle; the block does not enforce it.
module premultiplied_alpha_compositor_top #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_preview_pixel,
    input  logic [31:0] i_back_pixel,
    input  logic [31:0] i_front_pixel,
    input  logic [11:0] i_column,
    input  logic [11:0] i_row,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_composited_pixel
);

    localparam int          NumStages = 6;
    localparam logic [31:0] MaxWidth  = 32'(MAX_WIDTH);

    // Configuration registers.
    logic [1:0]  r_lane [4];
    logic [1:0]  r_bg_mode;
    logic [23:0] r_first_color;
    logic [23:0] r_second_color;
    logic [12:0] r_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane[0]      <= 2'd0;
            r_lane[1]      <= 2'd1;
            r_lane[2]      <= 2'd2;
            r_lane[3]      <= 2'd3;
            r_bg_mode      <= pac_pkg::BG_NONE;
            r_first_color  <= 24'd0;
            r_second_color <= 24'd0;
            r_width        <= 13'd64;
        end else if (i_cfg_we) begin
            case (pac_pkg::t_reg_idx'(i_cfg_idx))
                pac_pkg::REG_RED_LANE:      r_lane[0]      <= i_cfg_data[1:0];
                pac_pkg::REG_GREEN_LANE:    r_lane[1]      <= i_cfg_data[1:0];
                pac_pkg::REG_BLUE_LANE:     r_lane[2]      <= i_cfg_data[1:0];
                pac_pkg::REG_ALPHA_LANE:    r_lane[3]      <= i_cfg_data[1:0];
                pac_pkg::REG_BG_MODE:       r_bg_mode      <= i_cfg_data[1:0];
                pac_pkg::REG_FIRST_COLOR:   r_first_color  <= i_cfg_data;
                pac_pkg::REG_SECOND_COLOR:  r_second_color <= i_cfg_data;
                pac_pkg::REG_PREVIEW_WIDTH: r_width        <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // Pipeline flow control: a stage loads when it is empty or the stage after it moves.
    logic [NumStages-1:0] r_vld;
    logic [NumStages:0]   en;

    always_comb begin
        en[NumStages] = i_out_ready;
        for (int k = NumStages - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NumStages; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_ready  = en[0];
    assign o_out_valid = r_vld[NumStages-1];

    // Stage A: back pixel under the preview pixel, plus checker phase and front alpha.
    pac_pkg::t_px pv, bk, fr;
    pac_pkg::t_px n_a_px;
    logic [7:0]   a_alpha, a_na, f_alpha;
    logic [4:0]   w5, diff5;
    logic         n_a_odd;

    assign pv = i_preview_pixel;
    assign bk = i_back_pixel;
    assign fr = i_front_pixel;

    always_comb begin
        logic [2:0] cnt;
        logic [7:0] t;
        logic [7:0] add;
        a_alpha = pv[r_lane[3]];
        a_na    = pac_pkg::ALPHA_MAX - a_alpha;
        for (int l = 0; l < 4; l++) begin
            // A lane named by several lane registers receives the term once per name.
            cnt = 3'(r_lane[0] == 2'(l)) + 3'(r_lane[1] == 2'(l))
                + 3'(r_lane[2] == 2'(l)) + 3'(r_lane[3] == 2'(l));
            t   = pac_pkg::blend_term(bk[l], a_na);
            add = (cnt[0] ? t : 8'd0) + (cnt[1] ? {t[6:0], 1'b0} : 8'd0)
                + (cnt[2] ? {t[5:0], 2'b0} : 8'd0);
            if (a_alpha == pac_pkg::ALPHA_MIN) begin
                n_a_px[l] = bk[l];
            end else if (a_alpha == pac_pkg::ALPHA_MAX) begin
                n_a_px[l] = pv[l];
            end else begin
                n_a_px[l] = pv[l] + add;
            end
        end
    end

    // Only bit 4 of (width - column) and of row decide the checker square parity.
    assign w5      = ({19'b0, r_width} > MaxWidth) ? MaxWidth[4:0] : r_width[4:0];
    assign diff5   = w5 - i_column[4:0];
    assign n_a_odd = diff5[4] ^ i_row[4];
    assign f_alpha = fr[r_lane[3]];

    pac_pkg::t_px r_a_px, r_a_fr;
    logic         r_a_odd;
    logic [7:0]   r_a_f;

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_a_px  <= n_a_px;
            r_a_fr  <= fr;
            r_a_odd <= n_a_odd;
            r_a_f   <= f_alpha;
        end
    end

    // Stage B: optional background under the pixel.
    pac_pkg::t_px n_b_px;
    logic [23:0]  bg_color;
    logic         bg_on;
    logic [7:0]   b_na;

    always_comb begin
        bg_on    = (r_bg_mode == pac_pkg::BG_SOLID) || (r_bg_mode == pac_pkg::BG_CHECK);
        bg_color = (r_bg_mode == pac_pkg::BG_CHECK && r_a_odd) ? r_second_color
                                                                 : r_first_color;
        b_na     = pac_pkg::ALPHA_MAX - r_a_px[3];
        n_b_px   = r_a_px;
        if (bg_on && r_a_px[3] != pac_pkg::ALPHA_MAX) begin
            for (int l = 0; l < 3; l++) begin
                if (r_a_px[3] == pac_pkg::ALPHA_MIN) begin
                    n_b_px[l] = bg_color[8*l +: 8];
                end else begin
                    n_b_px[l] = r_a_px[l] + pac_pkg::blend_term(bg_color[8*l +: 8], b_na);
                end
            end
            n_b_px[3] = pac_pkg::ALPHA_MAX;
        end
    end

    pac_pkg::t_px r_b_px, r_b_fr;
    logic [7:0]   r_b_f;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_b_px <= n_b_px;
            r_b_fr <= r_a_fr;
            r_b_f  <= r_a_f;
        end
    end

    // Stages C0..C3: front pixel over the result, one lane register per stage.
    pac_pkg::t_px c_px_in [4];
    pac_pkg::t_px c_fr_in [4];
    logic [7:0]   c_f_in  [4];
    pac_pkg::t_px r_c_px  [4];
    pac_pkg::t_px r_c_fr  [4];
    logic [7:0]   r_c_f   [4];

    assign c_px_in[0] = r_b_px;
    assign c_fr_in[0] = r_b_fr;
    assign c_f_in[0]  = r_b_f;

    for (genvar k = 0; k < 4; k++) begin : g_front
        pac_pkg::t_px n_c_px;
        logic [1:0]   ln;
        logic [7:0]   f_na;

        if (k > 0) begin : g_link
            assign c_px_in[k] = r_c_px[k-1];
            assign c_fr_in[k] = r_c_fr[k-1];
            assign c_f_in[k]  = r_c_f[k-1];
        end

        assign ln   = r_lane[k];
        assign f_na = pac_pkg::ALPHA_MAX - c_f_in[k];

        always_comb begin
            n_c_px = c_px_in[k];
            if (c_f_in[k] == pac_pkg::ALPHA_MAX) begin
                // An opaque front pixel replaces the result; the first stage does it.
                if (k == 0) begin
                    n_c_px = c_fr_in[k];
                end
            end else if (c_f_in[k] != pac_pkg::ALPHA_MIN) begin
                n_c_px[ln] = c_fr_in[k][ln] + pac_pkg::blend_term(c_px_in[k][ln], f_na);
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[k+2]) begin
                r_c_px[k] <= n_c_px;
                r_c_fr[k] <= c_fr_in[k];
                r_c_f[k]  <= c_f_in[k];
            end
        end
    end

    assign o_composited_pixel = r_c_px[3];

endmodule

>>> rtl/core/pac_checker.sv
`timescale 1ns / 1ps

module pac_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_composited_pixel
);

    // Reset empties the pipeline.
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A stalled result stays put until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_composited_pixel))
        else $error("stalled result changed or vanished");

    // With no result waiting, nothing can block the pipeline.
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input not ready while output stage is empty");

    // When a result is taken, every stage moves and a new pixel can enter.
    a_flow_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready |-> o_in_ready)
        else $error("input not ready during output transfer");

endmodule

bind premultiplied_alpha_compositor_top pac_checker u_pac_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_in_ready         (o_in_ready),
    .o_out_valid        (o_out_valid),
    .i_out_ready        (i_out_ready),
    .o_composited_pixel (o_composited_pixel)
);

>>> verif/tb_premultiplied_alpha_compositor_top.sv
`timescale 1ns / 1ps

module tb_premultiplied_alpha_compositor_top;

    localparam int PV_MAX_WIDTH = 4096;
    localparam int PIPE_LAT     = 6;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DIR_N        = 25;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 48;

    // The unused background code, which must act as no background.
    localparam logic [1:0] BG_UNUSED = 2'd3;

    // Lane layouts packed as {alpha, blue, green, red}, two bits each.
    localparam logic [7:0] LANES_RGBA   = 8'hE4;
    localparam logic [7:0] LANES_SWAP   = 8'h1B;
    localparam logic [7:0] LANES_ALL_0  = 8'h00;
    localparam logic [7:0] LANES_ALL_3  = 8'hFF;

    localparam logic [23:0] DIR_FIRST  = 24'hCC6633;
    localparam logic [23:0] DIR_SECOND = 24'h0F1E2D;

    typedef struct packed {
        logic [7:0]  lanes;
        logic [1:0]  mode;
        logic [12:0] width;
        logic [31:0] preview;
        logic [31:0] back;
        logic [31:0] front;
        logic [11:0] column;
        logic [11:0] row;
        logic        typed;
        logic [31:0] want;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [23:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [31:0] i_preview_pixel = '0;
    logic [31:0] i_back_pixel = '0;
    logic [31:0] i_front_pixel = '0;
    logic [11:0] i_column = '0;
    logic [11:0] i_row = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [31:0] o_composited_pixel;

    // Copy of the register file as the block should see it.
    logic [3:0][1:0] lane_of  = LANES_RGBA;
    logic [1:0]      bg_mode  = pac_pkg::BG_NONE;
    logic [23:0]     color0   = '0;
    logic [23:0]     color1   = '0;
    logic [12:0]     pv_width = 13'd64;

    logic [31:0] pending_px[$];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatch_count = 0;
    int pixels_sent = 0;
    int pixels_checked = 0;
    int settings_used = 0;
    int cycle_count = 0;

    t_dir_row dir_rows [0:DIR_N-1];

    premultiplied_alpha_compositor_top #(
        .MAX_WIDTH(PV_MAX_WIDTH)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_preview_pixel(i_preview_pixel),
        .i_back_pixel(i_back_pixel),
        .i_front_pixel(i_front_pixel),
        .i_column(i_column),
        .i_row(i_row),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_composited_pixel(o_composited_pixel)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_px.size());
            $display("premultiplied_alpha_compositor_top test failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < 30)
            $display("ERROR at %0t: %s: got %08h, expected %08h", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : result_monitor
        logic [31:0] want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_px.size() == 0) begin
                report_mismatch("result with nothing pending", o_composited_pixel, '0);
            end else begin
                want = pending_px.pop_front();
                if (o_composited_pixel !== want)
                    report_mismatch("composited pixel", o_composited_pixel, want);
                pixels_checked++;
            end
        end
    end

    // Three blend steps on 8-bit lanes; every lane sum wraps modulo 256.
    function automatic pac_pkg::t_px composite_px(input pac_pkg::t_px pre,
                                                  input pac_pkg::t_px bk,
                                                  input pac_pkg::t_px fr,
                                                  input logic [11:0] col,
                                                  input logic [11:0] rw);
        pac_pkg::t_px d;
        logic [7:0] a;
        logic [7:0] f;
        logic [1:0] l;
        logic [23:0] colr;
        int na;
        int w;
        int x;
        int q;
        int k;
        d = pre;
        a = pre[lane_of[3]];
        if (a == pac_pkg::ALPHA_MIN) begin
            d = bk;
        end else if (a != pac_pkg::ALPHA_MAX) begin
            na = 255 - int'(a);
            // Aliased lanes are applied one after another on purpose.
            for (k = 0; k < 4; k++) begin
                l = lane_of[k];
                d[l] = 8'(int'(d[l]) + int'(bk[l]) * na / 255);
            end
        end

        if (bg_mode == pac_pkg::BG_SOLID || bg_mode == pac_pkg::BG_CHECK) begin
            colr = color0;
            w = (pv_width > PV_MAX_WIDTH) ? PV_MAX_WIDTH : int'(pv_width);
            x = w - int'(col);
            // The checker square index rounds toward minus infinity past the row end.
            q = (x >= 0) ? x / 16 : -((-x + 15) / 16);
            if (bg_mode == pac_pkg::BG_CHECK && (((q + int'(rw >> 4)) & 1) != 0))
                colr = color1;
            if (d[3] != pac_pkg::ALPHA_MAX) begin
                na = 255 - int'(d[3]);
                for (k = 0; k < 3; k++) begin
                    if (d[3] == pac_pkg::ALPHA_MIN)
                        d[k] = colr[8*k +: 8];
                    else
                        d[k] = 8'(int'(d[k]) + int'(colr[8*k +: 8]) * na / 255);
                end
                d[3] = pac_pkg::ALPHA_MAX;
            end
        end

        f = fr[lane_of[3]];
        if (f == pac_pkg::ALPHA_MAX) begin
            d = fr;
        end else if (f != pac_pkg::ALPHA_MIN) begin
            na = 255 - int'(f);
            for (k = 0; k < 4; k++) begin
                l = lane_of[k];
                d[l] = 8'(int'(fr[l]) + int'(d[l]) * na / 255);
            end
        end
        return d;
    endfunction

    // Mostly well-formed premultiplied pixels, with opaque and clear alpha common.
    function automatic pac_pkg::t_px rand_pixel();
        pac_pkg::t_px p;
        logic [7:0] a;
        int pick;
        bit tidy;
        int k;
        pick = $urandom_range(9);
        if (pick < 2)
            a = pac_pkg::ALPHA_MIN;
        else if (pick < 4)
            a = pac_pkg::ALPHA_MAX;
        else
            a = 8'($urandom_range(255));
        tidy = ($urandom_range(9) < 7);
        for (k = 0; k < 4; k++)
            p[k] = tidy ? 8'($urandom_range(a)) : 8'($urandom);
        p[lane_of[3]] = a;
        return p;
    endfunction

    // Half the columns land near the row end so the checker phase flips often.
    function automatic logic [11:0] rand_column();
        int c;
        if ($urandom_range(1) == 0) begin
            c = int'($urandom_range(4095));
        end else begin
            c = ((pv_width > PV_MAX_WIDTH) ? PV_MAX_WIDTH : int'(pv_width))
                + int'($urandom_range(40)) - 20;
            if (c < 0)
                c = 0;
            if (c > 4095)
                c = 4095;
        end
        return 12'(c);
    endfunction

    task automatic write_reg(input pac_pkg::t_reg_idx idx, input logic [23:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            pac_pkg::REG_RED_LANE:      lane_of[0] = data[1:0];
            pac_pkg::REG_GREEN_LANE:    lane_of[1] = data[1:0];
            pac_pkg::REG_BLUE_LANE:     lane_of[2] = data[1:0];
            pac_pkg::REG_ALPHA_LANE:    lane_of[3] = data[1:0];
            pac_pkg::REG_BG_MODE:       bg_mode = data[1:0];
            pac_pkg::REG_FIRST_COLOR:   color0 = data;
            pac_pkg::REG_SECOND_COLOR:  color1 = data;
            pac_pkg::REG_PREVIEW_WIDTH: pv_width = data[12:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [23:0] red, input logic [23:0] green,
                                input logic [23:0] blue, input logic [23:0] alpha,
                                input logic [23:0] mode, input logic [23:0] c0,
                                input logic [23:0] c1, input logic [23:0] width);
        write_reg(pac_pkg::REG_RED_LANE, red);
        write_reg(pac_pkg::REG_GREEN_LANE, green);
        write_reg(pac_pkg::REG_BLUE_LANE, blue);
        write_reg(pac_pkg::REG_ALPHA_LANE, alpha);
        write_reg(pac_pkg::REG_BG_MODE, mode);
        write_reg(pac_pkg::REG_FIRST_COLOR, c0);
        write_reg(pac_pkg::REG_SECOND_COLOR, c1);
        write_reg(pac_pkg::REG_PREVIEW_WIDTH, width);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Hold the sender off until every pending result is out and the pipe is empty.
    task automatic drain_pipe();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_px.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_LAT + 2) @(posedge i_clk);
    endtask

    task automatic send_pixel(input pac_pkg::t_px pre, input pac_pkg::t_px bk,
                              input pac_pkg::t_px fr,
                              input logic [11:0] col, input logic [11:0] rw,
                              input logic typed, input logic [31:0] want);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_preview_pixel <= pre;
        i_back_pixel    <= bk;
        i_front_pixel   <= fr;
        i_column        <= col;
        i_row           <= rw;
        do @(posedge i_clk); while (!o_in_ready);
        pending_px.push_back(typed ? want : 32'(composite_px(pre, bk, fr, col, rw)));
        pixels_sent++;
    endtask

    initial begin
        int i;
        int phase;
        t_dir_row r;

        dir_rows = '{
            // Reset settings: opaque preview, clear preview, opaque front, extremes.
            '{LANES_RGBA, pac_pkg::BG_NONE, 13'd64, 32'hFF112233, 32'h00000000,
              32'h00000000, 12'd0, 12'd0, 1'b1, 32'hFF112233},
            '{LANES_RGBA, pac_pkg::BG_NONE, 13'd64, 32'h00ABCDEF, 32'h80402010,
              32'h00000000, 12'd4095, 12'd4095, 1'b1, 32'h80402010},
            '{LANES_RGBA, pac_pkg::BG_NONE, 13'd64, 32'h7F102030, 32'h12345678,
              32'hFF00FF00, 12'd0, 12'd4095, 1'b1, 32'hFF00FF00},
            '{LANES_RGBA, pac_pkg::BG_NONE, 13'd64, 32'h00000000, 32'h00000000,
              32'h00000000, 12'd0, 12'd0, 1'b1, 32'h00000000},
            '{LANES_RGBA, pac_pkg::BG_NONE, 13'd64, 32'hFFFFFFFF, 32'hFFFFFFFF,
              32'hFFFFFFFF, 12'd4095, 12'd4095, 1'b1, 32'hFFFFFFFF},
            '{LANES_RGBA, pac_pkg::BG_NONE, 13'd64, 32'h80808080, 32'hFFFFFFFF,
              32'h00000000, 12'd5, 12'd7, 1'b0, 32'h0},
            // Lane sums that wrap past 255.
            '{LANES_RGBA, pac_pkg::BG_NONE, 13'd64, 32'h01FFFFFF, 32'hFFFFFFFF,
              32'h00000000, 12'd1, 12'd2, 1'b0, 32'h0},
            '{LANES_RGBA, pac_pkg::BG_NONE, 13'd64, 32'h80404040, 32'h00000000,
              32'h40FFFFFF, 12'd3, 12'd4, 1'b0, 32'h0},
            '{LANES_RGBA, pac_pkg::BG_NONE, 13'd64, 32'h80404040, 32'hFF203040,
              32'h01010101, 12'd9, 12'd9, 1'b0, 32'h0},
            // Solid background under a clear, an opaque and a partial pixel.
            '{LANES_RGBA, pac_pkg::BG_SOLID, 13'd64, 32'h00000000, 32'h00000000,
              32'h00000000, 12'd0, 12'd0, 1'b1, {8'hFF, DIR_FIRST}},
            '{LANES_RGBA, pac_pkg::BG_SOLID, 13'd64, 32'hFF010203, 32'h00000000,
              32'h00000000, 12'd0, 12'd0, 1'b1, 32'hFF010203},
            '{LANES_RGBA, pac_pkg::BG_SOLID, 13'd64, 32'h40102030, 32'h00000000,
              32'h00000000, 12'd7, 12'd7, 1'b0, 32'h0},
            '{LANES_RGBA, pac_pkg::BG_SOLID, 13'd64, 32'h01FFFFFF, 32'h00000000,
              32'h00000000, 12'd7, 12'd7, 1'b0, 32'h0},
            // Checkerboard: both squares, columns past the row end, odd rows.
            '{LANES_RGBA, pac_pkg::BG_CHECK, 13'd64, 32'h00000000, 32'h00000000,
              32'h00000000, 12'd0, 12'd0, 1'b0, 32'h0},
            '{LANES_RGBA, pac_pkg::BG_CHECK, 13'd64, 32'h00000000, 32'h00000000,
              32'h00000000, 12'd16, 12'd0, 1'b0, 32'h0},
            '{LANES_RGBA, pac_pkg::BG_CHECK, 13'd64, 32'h40102030, 32'h00000000,
              32'h00000000, 12'd100, 12'd0, 1'b0, 32'h0},
            '{LANES_RGBA, pac_pkg::BG_CHECK, 13'd64, 32'h00000000, 32'h00000000,
              32'h00000000, 12'd4095, 12'd4095, 1'b0, 32'h0},
            // Width beyond the maximum clamps; width of one pixel; the unused background mode.
            '{LANES_RGBA, pac_pkg::BG_CHECK, 13'd8191, 32'h00000000, 32'h00000000,
              32'h00000000, 12'd4095, 12'd16, 1'b0, 32'h0},
            '{LANES_RGBA, pac_pkg::BG_CHECK, 13'd1, 32'h20101010, 32'h00000000,
              32'h00000000, 12'd0, 12'd31, 1'b0, 32'h0},
            '{LANES_RGBA, BG_UNUSED, 13'd64, 32'h00000000, 32'h00000000,
              32'h00000000, 12'd0, 12'd0, 1'b1, 32'h00000000},
            // All lanes on one byte, a reversed layout, then all lanes on the top byte.
            '{LANES_ALL_0, pac_pkg::BG_NONE, 13'd64, 32'h00000080, 32'hFFFFFFFF,
              32'h00000000, 12'd0, 12'd0, 1'b0, 32'h0},
            '{LANES_ALL_0, pac_pkg::BG_NONE, 13'd64, 32'h00000080, 32'h00000000,
              32'h000000C0, 12'd0, 12'd0, 1'b0, 32'h0},
            '{LANES_SWAP, pac_pkg::BG_NONE, 13'd64, 32'h20304080, 32'h11223344,
              32'h00000000, 12'd0, 12'd0, 1'b0, 32'h0},
            '{LANES_SWAP, pac_pkg::BG_CHECK, 13'd64, 32'h10203040, 32'h55667788,
              32'h00000010, 12'd70, 12'd40, 1'b0, 32'h0},
            '{LANES_ALL_3, pac_pkg::BG_NONE, 13'd64, 32'h7F000000, 32'hFF000000,
              32'h80000000, 12'd0, 12'd0, 1'b0, 32'h0}
        };

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 31;
        recv_idle_pct = 80;
        for (i = 0; i < DIR_N; i++) begin
            r = dir_rows[i];
            if (r.lanes != lane_of || r.mode != bg_mode || r.width != pv_width) begin
                drain_pipe();
                program_regs(24'(r.lanes[1:0]), 24'(r.lanes[3:2]), 24'(r.lanes[5:4]),
                             24'(r.lanes[7:6]), 24'(r.mode), DIR_FIRST, DIR_SECOND,
                             24'(r.width));
            end
            send_pixel(r.preview, r.back, r.front, r.column, r.row, r.typed, r.want);
        end

        for (phase = 0; phase < PHASES; phase++) begin
            drain_pipe();
            if (phase < PHASES / 3) begin
                send_idle_pct = 31;
                recv_idle_pct = 80;
            end else if (phase < 2 * PHASES / 3) begin
                send_idle_pct = 80;
                recv_idle_pct = 31;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (phase)
                0: program_regs(24'd0, 24'd1, 24'd2, 24'd3, 24'(pac_pkg::BG_CHECK),
                                24'h000000, 24'hFFFFFF, 24'd1);
                1: program_regs(24'd3, 24'd3, 24'd3, 24'd3, 24'(pac_pkg::BG_SOLID),
                                24'hFFFFFF, 24'h000000, 24'd4096);
                2: program_regs(24'd3, 24'd2, 24'd1, 24'd0, 24'(BG_UNUSED),
                                24'($urandom), 24'($urandom), 24'd8191);
                3: program_regs(24'd0, 24'd1, 24'd2, 24'd3, 24'(pac_pkg::BG_CHECK),
                                24'($urandom), 24'($urandom), 24'd8191);
                default: program_regs(24'($urandom), 24'($urandom), 24'($urandom),
                                      24'($urandom), 24'($urandom), 24'($urandom),
                                      24'($urandom),
                                      24'($urandom_range(1, 8191))
                                      | (24'($urandom) & 24'hFFE000));
            endcase
            for (i = 0; i < PHASE_ITEMS; i++)
                send_pixel(rand_pixel(), rand_pixel(), rand_pixel(), rand_column(),
                           12'($urandom), 1'b0, 32'h0);
        end

        drain_pipe();
        repeat (PIPE_LAT * 3) @(posedge i_clk);

        $display("Sent %0d pixels (%0d from the directed table) under %0d register settings,",
                 pixels_sent, DIR_N, settings_used);
        $display("with lane remaps, all background modes and stalls; %0d checked, %0d bad.",
                 pixels_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("premultiplied_alpha_compositor_top test passed");
        end else begin
            $display("premultiplied_alpha_compositor_top test failed");
        end
        $finish;
    end

endmodule

>>> premultiplied_alpha_compositor_top.f
rtl/core/pac_pkg.sv
rtl/core/premultiplied_alpha_compositor_top.sv
rtl/core/pac_checker.sv
verif/tb_premultiplied_alpha_compositor_top.sv
